// ===== hw/rtl/cbm_pkg.sv =====
package cbm_pkg;

	// Codes for where a bus access lands.
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_ROM  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ROM_BANK_MASK = 2'd0;
	localparam logic [1:0] REG_RAM_BANK_MASK = 2'd1;
	localparam logic [1:0] REG_RAM_PRESENT   = 2'd2;

	// Access kinds.
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Low-nibble pattern that turns external RAM on.
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// Bus map boundaries, compared on the top address bits.
	localparam logic [2:0] RAM_WINDOW_TOP3 = 3'b101;   // 0xA000-0xBFFF

	// Sub-register select within the control area (bus_address[14:13]).
	localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;      // 0x0000-0x1FFF
	localparam logic [1:0] CTL_ROM_LOW    = 2'd1;      // 0x2000-0x3FFF
	localparam logic [1:0] CTL_BANK_HIGH  = 2'd2;      // 0x4000-0x5FFF
	localparam logic [1:0] CTL_MODE       = 2'd3;      // 0x6000-0x7FFF

	localparam int ROM_BANK_W  = 7;
	localparam int RAM_BANK_W  = 2;
	localparam int MEM_ADDR_W  = 21;

	// One bus access.
	typedef struct packed {
		logic        kind;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
	} in_word_t;

	// One mapped access.
	typedef struct packed {
		logic [1:0]            target;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic                  mem_write;
		logic [7:0]            mem_data;
	} out_word_t;

endpackage

// ===== hw/rtl/cartridge_bank_mapper_top.sv =====
// Cartridge bank mapper. Each word on the input channel is one CPU bus access
// (read or write, 16-bit address, data byte) and yields exactly one word on the
// output channel: the target (none, ROM or external RAM), the flat memory
// address, the RAM write strobe and the byte to store. Writes to 0x0000-0x7FFF
// update the RAM enable, the ROM bank bits, the RAM bank and the banking mode
// and give target none; a target of none on a read means the bus sees 0xFF.
// The block takes one word per cycle while out_stall is low: a word passes an
// input register, a single level of decode and bank logic, and a result
// register, which offers it on the output channel. A stalled output holds both
// registers; while the output flows, the next words follow back to back.
// The configuration registers may only be written while the block is idle.
module cartridge_bank_mapper_top #(
	parameter int ROM_BANKS = 128,
	parameter int RAM_BANKS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  cbm_pkg::in_word_t  in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output cbm_pkg::out_word_t out_word,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [6:0]       cfg_data
);
	import cbm_pkg::*;

	localparam logic [ROM_BANK_W-1:0] ROM_LIMIT = ROM_BANK_W'(ROM_BANKS - 1);
	localparam logic [RAM_BANK_W-1:0] RAM_LIMIT = RAM_BANK_W'(RAM_BANKS - 1);

	// Configuration registers.
	logic [ROM_BANK_W-1:0] rom_bank_mask_q;
	logic [RAM_BANK_W-1:0] ram_bank_mask_q;
	logic                  ram_present_q;

	// Bank state.
	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [RAM_BANK_W-1:0] ram_bank_q;
	logic                  ram_enable_q;
	logic                  banking_mode_q;

	// Pipeline registers.
	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	out_word_t word_s2;

	logic      adv_s2;
	logic      adv_s1;
	logic      take_in;

	logic [ROM_BANK_W-1:0] eff_rom_mask;
	logic [RAM_BANK_W-1:0] eff_ram_mask;
	logic [4:0]            rom_low;
	out_word_t             result;
	logic [ROM_BANK_W-1:0] rom_bank_d;
	logic [RAM_BANK_W-1:0] ram_bank_d;
	logic                  ram_enable_d;
	logic                  banking_mode_d;

	// Handshake: the result register frees when taken, the input register
	// frees when its word moves on.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign take_in  = in_valid && !in_stall;

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

	assign eff_rom_mask = rom_bank_mask_q & ROM_LIMIT;
	assign eff_ram_mask = ram_bank_mask_q & RAM_LIMIT;

	// A zero in the lower bank bits selects bank one instead.
	assign rom_low = (word_s1.write_data[4:0] == 5'd0) ? 5'd1 : word_s1.write_data[4:0];

	// Decode the access in the input register and work out the next bank state.
	always_comb begin
		result         = '0;
		result.target  = TGT_NONE;
		rom_bank_d     = rom_bank_q;
		ram_bank_d     = ram_bank_q;
		ram_enable_d   = ram_enable_q;
		banking_mode_d = banking_mode_q;
		if (!word_s1.bus_address[15]) begin
			if (word_s1.kind == KIND_READ) begin
				result.target = TGT_ROM;
				if (!word_s1.bus_address[14]) begin
					result.mem_address = MEM_ADDR_W'(word_s1.bus_address);
				end else begin
					result.mem_address = {rom_bank_q, word_s1.bus_address[13:0]};
				end
			end else begin
				case (word_s1.bus_address[14:13])
					CTL_RAM_ENABLE: begin
						ram_enable_d = (word_s1.write_data[3:0] == RAM_ENABLE_KEY);
					end
					CTL_ROM_LOW: begin
						rom_bank_d = {rom_bank_q[6:5], rom_low} & eff_rom_mask;
					end
					CTL_BANK_HIGH: begin
						if (banking_mode_q) begin
							ram_bank_d = word_s1.write_data[1:0] & eff_ram_mask;
						end else begin
							rom_bank_d = {word_s1.write_data[1:0], rom_bank_q[4:0]}
								& eff_rom_mask;
						end
					end
					CTL_MODE: begin
						banking_mode_d = word_s1.write_data[0];
					end
					default: begin
						banking_mode_d = banking_mode_q;
					end
				endcase
			end
		end else if (word_s1.bus_address[15:13] == RAM_WINDOW_TOP3
				&& ram_present_q && ram_enable_q) begin
			result.target      = TGT_RAM;
			result.mem_address = MEM_ADDR_W'({ram_bank_q, word_s1.bus_address[12:0]});
			if (word_s1.kind == KIND_WRITE) begin
				result.mem_write = 1'b1;
				result.mem_data  = word_s1.write_data;
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_mask_q <= ROM_BANK_W'(1);
			ram_bank_mask_q <= '0;
			ram_present_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROM_BANK_MASK: rom_bank_mask_q <= cfg_data[ROM_BANK_W-1:0];
				REG_RAM_BANK_MASK: ram_bank_mask_q <= cfg_data[RAM_BANK_W-1:0];
				REG_RAM_PRESENT:   ram_present_q   <= cfg_data[0];
				default: begin
					ram_present_q <= ram_present_q;
				end
			endcase
		end
	end

	// Bank state changes as a word leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q     <= ROM_BANK_W'(1);
			ram_bank_q     <= '0;
			ram_enable_q   <= 1'b0;
			banking_mode_q <= 1'b0;
		end else if (adv_s1) begin
			rom_bank_q     <= rom_bank_d;
			ram_bank_q     <= ram_bank_d;
			ram_enable_q   <= ram_enable_d;
			banking_mode_q <= banking_mode_d;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_word;
		end
		if (adv_s1) begin
			word_s2 <= result;
		end
	end

endmodule
